FILE: rtl/core/spk_pkg.sv
package spk_pkg;

  localparam int unsigned WordW      = 24;
  localparam int unsigned SchedSteps = 22;
  localparam int unsigned RoundCount = 23;
  localparam int unsigned StepIdxW   = 5;

  typedef logic [WordW-1:0]    word_t;
  typedef logic [StepIdxW-1:0] step_idx_t;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } op_e;

  // One block in flight together with the live key schedule window.
  typedef struct packed {
    op_e   op;
    word_t x;
    word_t y;
    word_t rk;
    word_t l0;
    word_t l1;
    word_t l2;
  } spk_item_t;

  function automatic word_t rotl3(input word_t v);
    rotl3 = {v[WordW-4:0], v[WordW-1:WordW-3]};
  endfunction

  function automatic word_t rotr3(input word_t v);
    rotr3 = {v[2:0], v[WordW-1:3]};
  endfunction

  function automatic word_t rotl8(input word_t v);
    rotl8 = {v[WordW-9:0], v[WordW-1:WordW-8]};
  endfunction

  function automatic word_t rotl16(input word_t v);
    rotl16 = {v[WordW-17:0], v[WordW-1:WordW-16]};
  endfunction

  // Forward key schedule step: advances the window by one round key.
  function automatic spk_item_t sched_fwd(input spk_item_t it, input step_idx_t idx);
    spk_item_t r;
    word_t     nl;
    r     = it;
    nl    = (rotl16(it.l0) + it.rk) ^ word_t'(idx);
    r.rk  = rotl3(it.rk) ^ nl;
    r.l0  = it.l1;
    r.l1  = it.l2;
    r.l2  = nl;
    sched_fwd = r;
  endfunction

  // Inverse of sched_fwd for the same step index.
  function automatic spk_item_t sched_bwd(input spk_item_t it, input step_idx_t idx);
    spk_item_t r;
    word_t     rk_prev;
    r       = it;
    rk_prev = rotr3(it.rk ^ it.l2);
    r.rk    = rk_prev;
    r.l0    = rotl8((it.l2 ^ word_t'(idx)) - rk_prev);
    r.l1    = it.l0;
    r.l2    = it.l1;
    sched_bwd = r;
  endfunction

endpackage

FILE: rtl/core/speck48_96_block_cipher.sv
// Speck 48/96 block cipher, fully pipelined: one block, with its own key and
// direction, may be transferred in every cycle, and each result passes
// through 22 key cells, 23 round cells and the output register. Each key
// cell does at most one key schedule step and each round cell one round.
// Blocks are independent, so encryptions and decryptions under different
// keys may be freely mixed. A two-entry output stage (output register plus
// skid register) lets the pipeline keep moving while a finished result waits
// to be taken; the input is refused only once both entries hold results.
module speck48_96_block_cipher
  import spk_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  opcode_i,
  input  word_t key_word0_i,
  input  word_t key_word1_i,
  input  word_t key_word2_i,
  input  word_t key_word3_i,
  input  word_t block_low_i,
  input  word_t block_high_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t result_low_o,
  output word_t result_high_o
);

  localparam int unsigned Stages = SchedSteps + RoundCount;

  // Stage 0 is the input itself; stage k+1 is the register of cell k.
  spk_item_t       pipe  [Stages+1];
  logic [Stages:0] pipe_vld;
  logic            en;

  logic  out_vld_q, skid_vld_q;
  word_t out_x_q, out_y_q, skid_x_q, skid_y_q;

  // The whole chain advances together; it only halts when the skid entry
  // is occupied, which means two results are waiting at the output.
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // The schedule window starts as the key words in model order: the first
  // round key, then the three older schedule words.
  always_comb begin
    pipe[0].op = op_e'(opcode_i);
    pipe[0].x  = block_low_i;
    pipe[0].y  = block_high_i;
    pipe[0].rk = key_word3_i;
    pipe[0].l0 = key_word2_i;
    pipe[0].l1 = key_word1_i;
    pipe[0].l2 = key_word0_i;
  end
  assign pipe_vld[0] = in_valid_i;

  // Key cells: a decryption has its schedule run to the last round key here,
  // while an encryption passes through untouched.
  for (genvar k = 0; k < SchedSteps; k++) begin : g_key
    spk_key_cell #(
      .StepIdx(step_idx_t'(k))
    ) u_key_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(pipe_vld[k]),
      .item_i (pipe[k]),
      .valid_o(pipe_vld[k+1]),
      .item_o (pipe[k+1])
    );
  end

  // Round cells: one round each; all but the last step the schedule forward
  // for encryption and backward for decryption, so the next cell sees its key.
  for (genvar j = 0; j < RoundCount; j++) begin : g_round
    spk_round_cell #(
      .EncIdx (step_idx_t'(j)),
      .DecIdx ((j < SchedSteps) ? step_idx_t'(SchedSteps - 1 - j) : '0),
      .HasStep(j < SchedSteps)
    ) u_round_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(pipe_vld[SchedSteps+j]),
      .item_i (pipe[SchedSteps+j]),
      .valid_o(pipe_vld[SchedSteps+j+1]),
      .item_o (pipe[SchedSteps+j+1])
    );
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      if (!out_vld_q || out_ready_i) begin
        out_vld_q <= pipe_vld[Stages];
      end else if (pipe_vld[Stages]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_vld_q || out_ready_i) begin
        if (pipe_vld[Stages]) begin
          out_x_q <= pipe[Stages].x;
          out_y_q <= pipe[Stages].y;
        end
      end else if (pipe_vld[Stages]) begin
        skid_x_q <= pipe[Stages].x;
        skid_y_q <= pipe[Stages].y;
      end
    end else if (out_ready_i) begin
      out_x_q <= skid_x_q;
      out_y_q <= skid_y_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_low_o  = out_x_q;
  assign result_high_o = out_y_q;

endmodule

FILE: rtl/core/spk_key_cell.sv
module spk_key_cell
  import spk_pkg::*;
#(
  parameter step_idx_t StepIdx = '0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  spk_item_t item_i,
  output logic      valid_o,
  output spk_item_t item_o
);

  logic      valid_q;
  spk_item_t item_d, item_q;

  // Only decryption needs the schedule wound forward to its last key.
  always_comb begin
    item_d = item_i;
    if (item_i.op == OpDecrypt) begin
      item_d = sched_fwd(item_i, StepIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/spk_round_cell.sv
module spk_round_cell
  import spk_pkg::*;
#(
  parameter step_idx_t EncIdx  = '0,
  parameter step_idx_t DecIdx  = '0,
  parameter bit        HasStep = 1'b1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  spk_item_t item_i,
  output logic      valid_o,
  output spk_item_t item_o
);

  logic      valid_q;
  spk_item_t item_d, item_q;
  word_t     x_enc, y_enc, x_dec, y_dec;

  always_comb begin
    x_enc = (rotl16(item_i.x) + item_i.y) ^ item_i.rk;
    y_enc = rotl3(item_i.y) ^ x_enc;
    y_dec = rotr3(item_i.x ^ item_i.y);
    x_dec = rotl8((item_i.x ^ item_i.rk) - y_dec);

    item_d = item_i;
    if (item_i.op == OpEncrypt) begin
      if (HasStep) begin
        item_d = sched_fwd(item_i, EncIdx);
      end
      item_d.x = x_enc;
      item_d.y = y_enc;
    end else begin
      if (HasStep) begin
        item_d = sched_bwd(item_i, DecIdx);
      end
      item_d.x = x_dec;
      item_d.y = y_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: tb/tb_speck48_96_block_cipher.sv
`timescale 1ns / 1ps

module tb_speck48_96_block_cipher;
  import spk_pkg::*;

  // One 48-bit block as the two 24-bit halves that leave the cipher.
  typedef struct packed {
    word_t lo;
    word_t hi;
  } block_t;

  // Output-side stall patterns. Each one holds for a random stretch of cycles.
  typedef enum int unsigned {
    SinkFree,
    SinkRandom,
    SinkSparse,
    SinkLongStall
  } sink_mode_e;

  // Longer than the pipeline is deep, so this covers anything still in flight.
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomBlocks = 1300;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  logic  opcode_i = 1'b0;
  word_t key_word0_i = '0;
  word_t key_word1_i = '0;
  word_t key_word2_i = '0;
  word_t key_word3_i = '0;
  word_t block_low_i = '0;
  word_t block_high_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  word_t result_low_o;
  word_t result_high_o;

  // Blocks whose cipher output is still due, oldest first.
  block_t      expected_blocks[$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  speck48_96_block_cipher u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .key_word0_i  (key_word0_i),
    .key_word1_i  (key_word1_i),
    .key_word2_i  (key_word2_i),
    .key_word3_i  (key_word3_i),
    .block_low_i  (block_low_i),
    .block_high_i (block_high_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_low_o (result_low_o),
    .result_high_o(result_high_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A generous ceiling: even with every result held back by the slowest
  // stall pattern the run needs well under a tenth of this.
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // Rotate a 24-bit word left by s places.
  function automatic word_t rot_left(input word_t v, input int unsigned s);
    return (v << s) | (v >> (WordW - s));
  endfunction

  // Full Speck 48/96: expand the key into 23 round keys, then run the rounds
  // forward to encrypt, or their inverses in reverse order to decrypt.
  function automatic block_t speck_cipher(input op_e op, input word_t k0, input word_t k1,
                                          input word_t k2, input word_t k3,
                                          input word_t bx, input word_t by);
    word_t  round_key[RoundCount];
    word_t  oldest, middle, newest, fresh;
    word_t  x, y;
    block_t res;
    round_key[0] = k3;
    oldest = k2;
    middle = k1;
    newest = k0;
    for (int i = 0; i < SchedSteps; i++) begin
      fresh = (rot_left(oldest, 16) + round_key[i]) ^ word_t'(i);
      round_key[i+1] = rot_left(round_key[i], 3) ^ fresh;
      oldest = middle;
      middle = newest;
      newest = fresh;
    end
    x = bx;
    y = by;
    if (op == OpEncrypt) begin
      for (int i = 0; i < RoundCount; i++) begin
        x = (rot_left(x, 16) + y) ^ round_key[i];
        y = rot_left(y, 3) ^ x;
      end
    end else begin
      for (int i = RoundCount - 1; i >= 0; i--) begin
        y = rot_left(x ^ y, 21);
        x = rot_left(word_t'((x ^ round_key[i]) - y), 8);
      end
    end
    res.lo = x;
    res.hi = y;
    return res;
  endfunction

  // Mostly uniform words, with the extremes and single set or clear bits mixed
  // in so the carry chains and rotations see their corner values often.
  function automatic word_t pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WordW - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WordW - 1));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Present one block and hold it until the cipher takes it. The sender works
  // in bursts: when a burst runs out, valid drops for a random gap (sometimes
  // none) before the next burst starts. All drives happen at a rising edge.
  task automatic send_block(input op_e op, input word_t k0, input word_t k1,
                            input word_t k2, input word_t k3,
                            input word_t bx, input word_t by);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    key_word0_i  <= k0;
    key_word1_i  <= k1;
    key_word2_i  <= k2;
    key_word3_i  <= k3;
    block_low_i  <= bx;
    block_high_i <= by;
    // Ready is read at the edge before the design updates, i.e. the value it
    // had while this block was on the bus.
    do @(posedge clk_i); while (!in_ready_o);
    expected_blocks.push_back(speck_cipher(op, k0, k1, k2, k3, bx, by));
  endtask

  // Output side: the stall pattern is redrawn at random, ranging from always
  // ready through random and sparse ready to long stalls that fill the skid
  // stage and push back on the input.
  sink_mode_e  sink_mode = SinkFree;
  int unsigned sink_phase_left = 0;
  int unsigned sink_hold = 0;

  always @(posedge clk_i) begin
    if (sink_phase_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_phase_left = $urandom_range(20, 200);
    end
    sink_phase_left--;
    case (sink_mode)
      SinkFree: out_ready_i <= 1'b1;
      SinkRandom: out_ready_i <= ($urandom_range(0, 3) != 0);
      SinkSparse: out_ready_i <= (sink_phase_left % 4 == 0);
      default: begin
        if (sink_hold != 0) begin
          sink_hold--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) sink_hold = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // Every output transfer is checked against the oldest block still due.
  always @(posedge clk_i) begin
    block_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result lo=%06h hi=%06h", $time, result_low_o,
                 result_high_o);
        fail_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (result_low_o !== want.lo) begin
          $display("%0t: result_low expected %06h actual %06h", $time, want.lo,
                   result_low_o);
          fail_count++;
        end
        if (result_high_o !== want.hi) begin
          $display("%0t: result_high expected %06h actual %06h", $time, want.hi,
                   result_high_o);
          fail_count++;
        end
      end
    end
  end

  // The published 48/96 vector, encrypted and then decrypted back. The
  // predictor is first held against the published ciphertext so that a slip
  // in it cannot hide behind a matching slip in the design.
  task automatic test_known_vector();
    block_t ct;
    ct = speck_cipher(OpEncrypt, 24'h1a1918, 24'h121110, 24'h0a0908, 24'h020100,
                      24'h6d2073, 24'h696874);
    if (ct.lo !== 24'h735e10 || ct.hi !== 24'hb6445d) begin
      $display("%0t: known vector expected 735e10/b6445d actual %06h/%06h", $time,
               ct.lo, ct.hi);
      fail_count++;
    end
    send_block(OpEncrypt, 24'h1a1918, 24'h121110, 24'h0a0908, 24'h020100,
               24'h6d2073, 24'h696874);
    send_block(OpDecrypt, 24'h1a1918, 24'h121110, 24'h0a0908, 24'h020100,
               24'h735e10, 24'hb6445d);
  endtask

  // All-zero and all-one keys and blocks in both directions, plus the two
  // alternating bit patterns.
  task automatic test_field_extremes();
    word_t k, b;
    for (int o = 0; o < 2; o++) begin
      for (int kk = 0; kk < 2; kk++) begin
        for (int bb = 0; bb < 2; bb++) begin
          k = kk ? '1 : '0;
          b = bb ? '1 : '0;
          send_block(op_e'(o), k, k, k, k, b, b);
        end
      end
      send_block(op_e'(o), 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
                 24'haaaaaa, 24'h555555);
    end
  endtask

  // Independent blocks with fresh keys and a random direction each time.
  task automatic test_random_blocks();
    for (int n = 0; n < RandomBlocks; n++) begin
      send_block(op_e'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
                 pick_word(), pick_word(), pick_word());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_known_vector();
    test_field_extremes();
    test_random_blocks();
    in_valid_i <= 1'b0;

    // Let every outstanding block come out, then watch for stray results.
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
